>>> hdl/rope_pkg.sv
// ----------------------------------------------------------------------------
// rope_pkg: shared types and constants for the rotary position embedding block
// Beat formats, configuration view, queue entry and sizing constants.
// ----------------------------------------------------------------------------
package rope_pkg;

    // Sizing
    localparam int MAX_POSITIONS = 2048;
    localparam int MAX_PAIRS     = 64;
    localparam int MAX_HEAD      = 256;
    localparam int DATA_WIDTH    = 16;
    localparam int COEF_WIDTH    = 16;
    localparam int FRAC_BITS     = 14;

    localparam int ROW_W      = $clog2(MAX_POSITIONS);
    localparam int ROW_SUM_W  = ROW_W + 1;
    localparam int PAIR_W     = $clog2(MAX_PAIRS);
    localparam int NPAIR_W    = PAIR_W + 1;
    localparam int IDX_W      = $clog2(MAX_HEAD);
    localparam int LEN_W      = IDX_W + 1;
    localparam int TBL_ADDR_W = ROW_W + PAIR_W;
    localparam int TBL_DEPTH  = MAX_POSITIONS * MAX_PAIRS;
    localparam int TBL_W      = 2 * COEF_WIDTH;

    // Work queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 4;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_NEOX_PAIRING = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROTARY_PAIRS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEAD_LENGTH  = 2'd2;

    localparam logic [NPAIR_W-1:0] RST_ROTARY_PAIRS = NPAIR_W'(64);
    localparam logic [LEN_W-1:0]   RST_HEAD_LENGTH  = LEN_W'(128);
    localparam logic [LEN_W-1:0]   MIN_HEAD_LENGTH  = LEN_W'(2);

    typedef enum logic [0:0] {
        CMD_TABLE_WRITE = 1'b0,
        CMD_ELEMENT     = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                          cmd;
        logic [ROW_W-1:0]              table_row;
        logic [PAIR_W-1:0]             table_pair;
        logic signed [COEF_WIDTH-1:0]  cos_value;
        logic signed [COEF_WIDTH-1:0]  sin_value;
        logic [ROW_W-1:0]              position;
        logic [ROW_W-1:0]              cache_offset;
        logic signed [DATA_WIDTH-1:0]  element_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  result_value;
        logic [IDX_W-1:0]              element_index;
        logic                          last_of_run;
        logic                          range_error;
    } t_out_beat;

    // Effective configuration (clamped)
    typedef struct packed {
        logic                 neox_pairing;
        logic [NPAIR_W-1:0]   pair_count;
        logic [LEN_W-1:0]     head_len;
    } t_cfg;

    // One unit of work for the back end: a pass-through element or a pair
    typedef struct packed {
        logic                          pair;
        logic                          rotate;
        logic                          range_error;
        logic signed [DATA_WIDTH-1:0]  x;
        logic signed [DATA_WIDTH-1:0]  y;
        logic signed [COEF_WIDTH-1:0]  cos_value;
        logic signed [COEF_WIDTH-1:0]  sin_value;
        logic [IDX_W-1:0]              x_index;
        logic [IDX_W-1:0]              y_index;
    } t_work;

endpackage

>>> hdl/rotary_position_embedding.sv
// ----------------------------------------------------------------------------
// rotary_position_embedding: streaming rotary embedding for one head vector
// Front end pairs elements and reads cos/sin, back end rotates and emits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data) carries one beat per item:
//   a cos/sin table write (cmd = table write) or one head element. Element
//   indices come from an internal counter that wraps at the head length; the
//   row (position + cache_offset) is sampled on element 0 of every head.
//   Output channel (o_out_valid/i_out_ready/o_out_data) carries result beats:
//   one per pass-through element, two (x' then y') when a pair completes,
//   none for table writes or held first members.
//   Results pass stage 1, the queue, the product stage and the output buffer.
//   Throughput: one input beat per cycle while o_in_ready is high; the output
//   port moves one beat per cycle, which sets the sustained rate for
//   pair-dense streams. A 4-entry work queue between front and back absorbs
//   bursts; o_in_ready drops when the queue plus the in-flight entry would fill.
//   Receiver stall: results wait in the output buffer, the queue fills, then
//   input ready falls. Nothing is dropped.
//   Reset: counter, row and error flag clear, registers take their defaults.
//   The cos/sin table and the hold slots are not cleared and must be written
//   before they are read. No clearing pass.
//   APB: pready is always high; regs at 0x0 neox, 0x4 pairs, 0x8 head length.
// ----------------------------------------------------------------------------
module rotary_position_embedding import rope_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_beat               i_in_data,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_beat              o_out_data,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);
    t_cfg                   cfg;
    logic                   push;
    t_work                  push_data;
    logic                   pop;
    t_work                  pop_data;
    logic                   work_valid;
    logic [FIFO_CNT_W-1:0]  fifo_count;

    // Registers; effective L and P are clamped here
    rope_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front: classification, hold memory, table, one register stage
    rope_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_fifo_count (fifo_count),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    // Work queue decouples front from output stalls
    rope_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_not_empty (work_valid),
        .o_count     (fifo_count)
    );

    // Back: multiply stage, round/saturate, two-beat output buffer
    rope_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (pop_data),
        .i_work_valid (work_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

>>> hdl/rope_cfg.sv
// ----------------------------------------------------------------------------
// rope_cfg: APB configuration registers
// Holds the pairing mode, pair count and head length; presents clamped values.
// ----------------------------------------------------------------------------
module rope_cfg import rope_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);
    logic                  r_neox;
    logic [NPAIR_W-1:0]    r_pairs;
    logic [LEN_W-1:0]      r_head;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;
    logic [LEN_W-1:0]      len_eff;
    logic [IDX_W-1:0]      len_half;
    logic [NPAIR_W-1:0]    pairs_lim;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neox  <= 1'b1;
            r_pairs <= RST_ROTARY_PAIRS;
            r_head  <= RST_HEAD_LENGTH;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEOX_PAIRING: r_neox  <= pwdata[0];
                REG_ROTARY_PAIRS: r_pairs <= pwdata[NPAIR_W-1:0];
                REG_HEAD_LENGTH:  r_head  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEOX_PAIRING: prdata = APB_DATA_W'(r_neox);
            REG_ROTARY_PAIRS: prdata = APB_DATA_W'(r_pairs);
            REG_HEAD_LENGTH:  prdata = APB_DATA_W'(r_head);
            default:          prdata = '0;
        endcase
    end

    // L = clamp(head, 2, MAX_HEAD); P = min(pairs, MAX_PAIRS, L/2)
    always_comb begin
        if (r_head < MIN_HEAD_LENGTH) begin
            len_eff = MIN_HEAD_LENGTH;
        end else if (r_head > LEN_W'(MAX_HEAD)) begin
            len_eff = LEN_W'(MAX_HEAD);
        end else begin
            len_eff = r_head;
        end
        len_half  = len_eff[LEN_W-1:1];
        pairs_lim = (r_pairs > NPAIR_W'(MAX_PAIRS)) ? NPAIR_W'(MAX_PAIRS) : r_pairs;
        o_cfg.neox_pairing = r_neox;
        o_cfg.head_len     = len_eff;
        o_cfg.pair_count   = ({1'b0, pairs_lim} > len_half) ? len_half[NPAIR_W-1:0]
                                                             : pairs_lim;
    end

endmodule

>>> hdl/rope_front.sv
// ----------------------------------------------------------------------------
// rope_front: input side of the rotary embedding block
// Counts elements, latches the row, pairs elements through the hold memory,
// loads and reads the cos/sin table, and queues work for the back end.
// ----------------------------------------------------------------------------
module rope_front import rope_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_beat               i_in_data,
    input  logic [FIFO_CNT_W-1:0]  i_fifo_count,
    output logic                   o_push,
    output t_work                  o_push_data
);
    // Storage
    logic [TBL_W-1:0]       r_tbl_mem [TBL_DEPTH];
    logic [DATA_WIDTH-1:0]  r_held_mem [MAX_PAIRS];
    logic [TBL_W-1:0]       r_tbl_rd;
    logic [DATA_WIDTH-1:0]  r_held_rd;

    // Head state
    logic [IDX_W-1:0]       r_count;
    logic [ROW_SUM_W-1:0]   r_row;
    logic                   r_row_bad;

    // Stage 1 (waits for memory read data)
    logic                          r_s1_valid;
    logic                          r_s1_pair;
    logic                          r_s1_err;
    logic signed [DATA_WIDTH-1:0]  r_s1_y;
    logic [IDX_W-1:0]              r_s1_xi;
    logic [IDX_W-1:0]              r_s1_yi;

    logic                   accept;
    logic                   is_elem;
    logic [IDX_W-1:0]       idx;
    logic [LEN_W-1:0]       idx_inc;
    logic [IDX_W-1:0]       n_count;
    logic [ROW_SUM_W-1:0]   row_new;
    logic [ROW_SUM_W-1:0]   row_now;
    logic                   row_bad;
    logic                   rot_part;
    logic                   first_member;
    logic [IDX_W-1:0]       pair_off;
    logic [PAIR_W-1:0]      slot;
    logic [IDX_W-1:0]       x_index;
    logic                   hold_wr;
    logic                   pair_rd;
    logic                   tbl_wr;
    logic                   tbl_rd;
    logic                   n_s1_valid;

    // room for the in-flight stage-1 item plus this one
    assign o_in_ready = ({1'b0, i_fifo_count} + (FIFO_CNT_W+1)'(r_s1_valid))
                        < (FIFO_CNT_W+1)'(FIFO_DEPTH);

    always_comb begin
        accept  = i_in_valid && o_in_ready;
        is_elem = (i_in_data.cmd == CMD_ELEMENT);

        // counter restarts if the head length shrank under it
        idx     = ({1'b0, r_count} >= i_cfg.head_len) ? '0 : r_count;
        idx_inc = {1'b0, idx} + LEN_W'(1);
        n_count = (idx_inc >= i_cfg.head_len) ? '0 : idx_inc[IDX_W-1:0];

        row_new = {1'b0, i_in_data.position} + {1'b0, i_in_data.cache_offset};
        row_now = (idx == '0) ? row_new : r_row;
        row_bad = (idx == '0) ? (row_new >= ROW_SUM_W'(MAX_POSITIONS)) : r_row_bad;

        rot_part = {1'b0, idx} < {1'b0, i_cfg.pair_count, 1'b0};
        pair_off = idx - IDX_W'(i_cfg.pair_count);
        if (i_cfg.neox_pairing) begin
            first_member = idx < IDX_W'(i_cfg.pair_count);
            slot         = first_member ? idx[PAIR_W-1:0] : pair_off[PAIR_W-1:0];
            x_index      = pair_off;
        end else begin
            first_member = !idx[0];
            slot         = idx[PAIR_W:1];
            x_index      = {idx[IDX_W-1:1], 1'b0};
        end

        hold_wr    = accept && is_elem && rot_part && first_member;
        pair_rd    = accept && is_elem && rot_part && !first_member;
        tbl_wr     = accept && !is_elem;
        tbl_rd     = pair_rd && !row_bad;
        n_s1_valid = accept && is_elem && !(rot_part && first_member);
    end

    // cos/sin table: row and pair fields always fall inside the table
    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_tbl_mem[{i_in_data.table_row, i_in_data.table_pair}] <=
                {i_in_data.cos_value, i_in_data.sin_value};
        end
        if (tbl_rd) begin
            r_tbl_rd <= r_tbl_mem[{row_now[ROW_W-1:0], slot}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_wr) begin
            r_held_mem[slot] <= i_in_data.element_value;
        end
        if (pair_rd) begin
            r_held_rd <= r_held_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_count    <= '0;
            r_row      <= '0;
            r_row_bad  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (accept && is_elem) begin
                r_count <= n_count;
                if (idx == '0) begin
                    r_row     <= row_new;
                    r_row_bad <= row_bad;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_elem) begin
            r_s1_pair <= rot_part;
            r_s1_err  <= row_bad;
            r_s1_y    <= i_in_data.element_value;
            r_s1_xi   <= x_index;
            r_s1_yi   <= idx;
        end
    end

    always_comb begin
        o_push                  = r_s1_valid;
        o_push_data.pair        = r_s1_pair;
        o_push_data.rotate      = !r_s1_err;
        o_push_data.range_error = r_s1_err;
        o_push_data.x           = r_held_rd;
        o_push_data.y           = r_s1_y;
        o_push_data.cos_value   = r_tbl_rd[TBL_W-1:COEF_WIDTH];
        o_push_data.sin_value   = r_tbl_rd[COEF_WIDTH-1:0];
        o_push_data.x_index     = r_s1_xi;
        o_push_data.y_index     = r_s1_yi;
    end

endmodule

>>> hdl/rope_fifo.sv
// ----------------------------------------------------------------------------
// rope_fifo: work queue between front and back
// Small register queue; front pushes, back pops.
// ----------------------------------------------------------------------------
module rope_fifo import rope_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_work                  i_push_data,
    input  logic                   i_pop,
    output t_work                  o_pop_data,
    output logic                   o_not_empty,
    output logic [FIFO_CNT_W-1:0]  o_count
);
    t_work                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    do_pop;

    assign o_count     = r_count;
    assign o_not_empty = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/rope_back.sv
// ----------------------------------------------------------------------------
// rope_back: rotation datapath and output stage
// Multiplies, then adds, rounds and saturates; emits one or two beats per item.
// ----------------------------------------------------------------------------
module rope_back import rope_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_work      i_work,
    input  logic       i_work_valid,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data
);
    localparam int PROD_W     = DATA_WIDTH + COEF_WIDTH;
    localparam int ACC_W      = PROD_W + 2;
    localparam int Q_W        = ACC_W - FRAC_BITS;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
    localparam int SAT_MAX    = (1 << (DATA_WIDTH - 1)) - 1;
    localparam int SAT_MIN    = -SAT_MAX - 1;

    // round half up, floor by 2^FRAC_BITS, saturate
    function automatic logic signed [DATA_WIDTH-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] v;
        logic signed [Q_W-1:0]   q;
        v = acc + ACC_W'(ROUND_BIAS);
        q = v[ACC_W-1:FRAC_BITS];
        if (q > Q_W'(SAT_MAX)) begin
            return DATA_WIDTH'(SAT_MAX);
        end else if (q < Q_W'(SAT_MIN)) begin
            return DATA_WIDTH'(SAT_MIN);
        end
        return q[DATA_WIDTH-1:0];
    endfunction

    // product stage
    logic                          r_p_valid;
    logic                          r_p_pair;
    logic                          r_p_rotate;
    logic                          r_p_err;
    logic signed [DATA_WIDTH-1:0]  r_p_x;
    logic signed [DATA_WIDTH-1:0]  r_p_y;
    logic signed [PROD_W-1:0]      r_p_xc;
    logic signed [PROD_W-1:0]      r_p_ys;
    logic signed [PROD_W-1:0]      r_p_yc;
    logic signed [PROD_W-1:0]      r_p_xs;
    logic [IDX_W-1:0]              r_p_xi;
    logic [IDX_W-1:0]              r_p_yi;

    // output buffer: up to two beats, head in r_out0
    logic [1:0]                    r_ocnt, n_ocnt;
    t_out_beat                     r_out0, n_out0;
    t_out_beat                     r_out1, n_out1;

    logic                          load_b;
    logic                          adv_p;
    logic signed [ACC_W-1:0]       acc_x;
    logic signed [ACC_W-1:0]       acc_y;
    logic signed [DATA_WIDTH-1:0]  val_x;
    logic signed [DATA_WIDTH-1:0]  val_y;

    assign load_b = (r_ocnt == 2'd0) || ((r_ocnt == 2'd1) && i_out_ready);
    assign adv_p  = !r_p_valid || load_b;
    assign o_pop  = i_work_valid && adv_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv_p) begin
            r_p_valid <= i_work_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_pair   <= i_work.pair;
            r_p_rotate <= i_work.rotate;
            r_p_err    <= i_work.range_error;
            r_p_x      <= i_work.x;
            r_p_y      <= i_work.y;
            r_p_xc     <= i_work.x * i_work.cos_value;
            r_p_ys     <= i_work.y * i_work.sin_value;
            r_p_yc     <= i_work.y * i_work.cos_value;
            r_p_xs     <= i_work.x * i_work.sin_value;
            r_p_xi     <= i_work.x_index;
            r_p_yi     <= i_work.y_index;
        end
    end

    always_comb begin
        acc_x = ACC_W'(r_p_xc) - ACC_W'(r_p_ys);
        acc_y = ACC_W'(r_p_yc) + ACC_W'(r_p_xs);
        val_x = r_p_rotate ? round_sat(acc_x) : r_p_x;
        val_y = r_p_rotate ? round_sat(acc_y) : r_p_y;
    end

    always_comb begin
        n_ocnt = r_ocnt;
        n_out0 = r_out0;
        n_out1 = r_out1;
        if ((r_ocnt == 2'd2) && i_out_ready) begin
            n_out0 = r_out1;
            n_ocnt = 2'd1;
        end else if (load_b && r_p_valid) begin
            if (r_p_pair) begin
                n_out0 = '{result_value: val_x, element_index: r_p_xi,
                           last_of_run: 1'b0, range_error: r_p_err};
                n_out1 = '{result_value: val_y, element_index: r_p_yi,
                           last_of_run: 1'b1, range_error: r_p_err};
                n_ocnt = 2'd2;
            end else begin
                n_out0 = '{result_value: r_p_y, element_index: r_p_yi,
                           last_of_run: 1'b1, range_error: r_p_err};
                n_ocnt = 2'd1;
            end
        end else if ((r_ocnt == 2'd1) && i_out_ready) begin
            n_ocnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
        end else begin
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out0 <= n_out0;
        r_out1 <= n_out1;
    end

    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_out_data  = r_out0;

endmodule
